// File: design/path_lookahead_target_select_top_defines.svh
// Assertion macros shared by the path lookahead target select design.
`ifndef PATH_LOOKAHEAD_TARGET_SELECT_TOP_DEFINES_SVH
`define PATH_LOOKAHEAD_TARGET_SELECT_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PLTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define PLTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/plts_pkg.sv
// Package of types, constants and codes for the path lookahead target select block.
`default_nettype none
package plts_pkg;
  localparam int MaxWaypoints = 256;
  localparam int AddrW = $clog2(MaxWaypoints);
  localparam int CountW = AddrW + 1;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [7:0]         target_index;
    logic               path_empty;
    logic               path_overflowed;
  } out_item_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_item;     // capture input coordinates
    logic clear_path;
    logic append_point;
    logic rd_issue;      // read memory at rd_addr
    logic [AddrW-1:0] rd_addr;
    logic dist_start;    // start squared distance on (ref, read point)
    logic take_best;     // compare distance, keep minimum
    logic init_best;
    logic load_ref;      // reference point <- read point
    logic sqrt_start;
    logic acc_clear;
    logic acc_add;
    logic set_target;    // target <- read point
    logic emit;
    logic emit_empty;
    logic [AddrW-1:0] tgt_idx;
  } ctrl_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              dist_done;
    logic              sqrt_done;
    logic              acc_below;
    logic [AddrW-1:0]  best_idx;
  } stat_t;
endpackage
`default_nettype wire

// File: design/path_lookahead_target_select_top.sv
// Top level of the path lookahead target select block.
// Usage:
//  An item is taken when start is high and busy is low. Action clear empties
//  the stored path, append adds one waypoint (dropped and flagged when full),
//  and query gives one result transaction, marked by done for one cycle.
//  Clear and append finish at the accepting edge, give no result and leave
//  busy low, so the next item can be taken at the following edge.
//  A query with n stored waypoints reads each waypoint and forms its squared
//  distance, then walks k segments, each set mostly by the 34-step
//  bit-serial square root. On an empty path the controller goes straight to
//  its emit state. Only one item is worked on at a time; busy stays high
//  until the cycle in which done is high.
//  The lookahead_distance register is written by cfg_we with cfg_data; the
//  user must write it only while idle, the block does not enforce this.
//  Reset empties the path, clears the overflow flag and sets the lookahead
//  to 2.0 m. Results cannot be stalled; done lasts one cycle.
`default_nettype none
module path_lookahead_target_select_top import plts_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire in_item_t item,
  output logic       busy,
  output logic       done,
  output out_item_t  result,
  input  wire        cfg_we,
  input  wire [31:0] cfg_data
);
  logic [31:0] lookahead_distance;
  ctrl_t ctrl;
  ctrl_t ctrl_dp;
  stat_t stat;

  // Lookahead register.
  always_ff @(posedge clk) begin
    if (rst) lookahead_distance <= 32'd131072;
    else if (cfg_we) lookahead_distance <= cfg_data;
  end

  plts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .stat   (stat),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  always_comb begin
    ctrl_dp = ctrl;
  end

  plts_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .item               (item),
    .lookahead_distance (lookahead_distance),
    .ctrl               (ctrl_dp),
    .stat               (stat),
    .result_valid       (done),
    .result             (result)
  );
endmodule
`default_nettype wire

// File: design/plts_sqrt.sv
// Bit-serial floor square root of a 66-bit value, one result bit per cycle.
`default_nettype none
module plts_sqrt import plts_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [65:0] radicand,
  output logic        done,
  output logic [33:0] root
);
  logic [67:0] rem;
  logic [67:0] val;
  logic [5:0]  step;
  logic        busy;
  logic [67:0] trial;
  logic [67:0] rem_sh;

  // Restoring digit recurrence: bring down two bits, try 4r+1.
  always_comb begin
    rem_sh = {rem[65:0], val[67:66]};
    trial  = rem_sh - {32'd0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'd34;
      end else if (busy) begin
        step <= step - 6'd1;
        if (step == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      val  <= {2'b00, radicand};
      root <= '0;
    end else if (busy) begin
      val <= {val[65:0], 2'b00};
      if (!trial[67]) begin
        rem  <= trial;
        root <= {root[32:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[32:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// File: design/plts_datapath.sv
// Datapath: waypoint memory, squared distance unit, minimum tracking and sum.
`default_nettype none
module plts_datapath import plts_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire in_item_t item,
  input  wire  [31:0] lookahead_distance,
  input  wire ctrl_t  ctrl,
  output stat_t       stat,
  output logic        result_valid,
  output out_item_t   result
);
  logic [31:0] mem_x [MaxWaypoints];
  logic [31:0] mem_y [MaxWaypoints];
  logic [31:0] mem_z [MaxWaypoints];
  logic [31:0] rd_x, rd_y, rd_z;
  logic [31:0] ref_x, ref_y, ref_z;
  logic [CountW-1:0] count;
  logic overflow;
  logic [65:0] dist_sq;
  logic [65:0] best_dist;
  logic [AddrW-1:0] best_idx;
  logic [1:0]  dstep;
  logic        dbusy;
  logic        ddone;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [65:0] sq;
  logic [32:0] mag_r;
  logic [31:0] acc;
  logic [33:0] root;
  logic        sqrt_done;
  logic [34:0] acc_sum;
  logic [31:0] tgt_x, tgt_y, tgt_z;

  // Memory write on append and registered read.
  always_ff @(posedge clk) begin
    if (ctrl.append_point && count < CountW'(MaxWaypoints)) begin
      mem_x[count[AddrW-1:0]] <= item.coord_x;
      mem_y[count[AddrW-1:0]] <= item.coord_y;
      mem_z[count[AddrW-1:0]] <= item.coord_z;
    end
    if (ctrl.rd_issue) begin
      rd_x <= mem_x[ctrl.rd_addr];
      rd_y <= mem_y[ctrl.rd_addr];
      rd_z <= mem_z[ctrl.rd_addr];
    end
  end

  // Fill count and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (ctrl.clear_path) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (ctrl.append_point) begin
      if (count < CountW'(MaxWaypoints)) count <= count + CountW'(1);
      else overflow <= 1'b1;
    end
  end

  // Reference point: the query position for the nearest search, then the
  // start waypoint of each walk segment.
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      ref_x <= item.coord_x;
      ref_y <= item.coord_y;
      ref_z <= item.coord_z;
    end else if (ctrl.load_ref) begin
      ref_x <= rd_x;
      ref_y <= rd_y;
      ref_z <= rd_z;
    end
  end

  // Axis difference selection; one axis per cycle.
  always_comb begin
    unique case (dstep)
      2'd0:    diff = 33'(signed'(ref_x)) - 33'(signed'(rd_x));
      2'd1:    diff = 33'(signed'(ref_y)) - 33'(signed'(rd_y));
      default: diff = 33'(signed'(ref_z)) - 33'(signed'(rd_z));
    endcase
    mag = diff[32] ? 33'(-diff) : 33'(diff);
    sq  = 66'(mag_r) * 66'(mag_r);
  end

  // Squared distance: magnitude registered, then squared and summed.
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
      dstep <= '0;
    end else begin
      ddone <= 1'b0;
      if (ctrl.dist_start) begin
        dbusy <= 1'b1;
        dstep <= 2'd0;
      end else if (dbusy) begin
        dstep <= dstep + 2'd1;
        if (dstep == 2'd3) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.dist_start) begin
      mag_r   <= '0;
      dist_sq <= '0;
    end else if (dbusy) begin
      mag_r <= mag;
      if (dstep != 2'd0) dist_sq <= dist_sq + sq;
    end
  end

  // Minimum tracking with the first lowest index kept on ties.
  always_ff @(posedge clk) begin
    if (ctrl.init_best) begin
      best_dist <= dist_sq;
      best_idx  <= '0;
    end else if (ctrl.take_best && dist_sq < best_dist) begin
      best_dist <= dist_sq;
      best_idx  <= ctrl.rd_addr;
    end
  end

  plts_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.sqrt_start),
    .radicand (dist_sq),
    .done     (sqrt_done),
    .root     (root)
  );

  // Saturating path length sum.
  assign acc_sum = 35'(acc) + 35'(root);
  always_ff @(posedge clk) begin
    if (ctrl.acc_clear) acc <= '0;
    else if (ctrl.acc_add) acc <= (acc_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];
    if (ctrl.set_target) begin
      tgt_x <= rd_x;
      tgt_y <= rd_y;
      tgt_z <= rd_z;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit;
    end
    if (ctrl.emit) begin
      result.target_x        <= ctrl.emit_empty ? 32'd0 : tgt_x;
      result.target_y        <= ctrl.emit_empty ? 32'd0 : tgt_y;
      result.target_z        <= ctrl.emit_empty ? 32'd0 : tgt_z;
      result.target_index    <= ctrl.emit_empty ? 8'd0 : 8'(ctrl.tgt_idx);
      result.path_empty      <= ctrl.emit_empty;
      result.path_overflowed <= overflow;
    end
  end

  assign stat.count     = count;
  assign stat.dist_done = ddone;
  assign stat.sqrt_done = sqrt_done;
  assign stat.acc_below = acc < lookahead_distance;
  assign stat.best_idx  = best_idx;
endmodule
`default_nettype wire

// File: design/plts_ctrl.sv
// Controller state machine sequencing appends, the nearest search and the walk.
`default_nettype none
module plts_ctrl import plts_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       start,
  input  wire [1:0] action,
  input  wire stat_t stat,
  output logic      busy,
  output ctrl_t     ctrl
);
  `include "path_lookahead_target_select_top_defines.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NRD    = 4'd1;
  localparam logic [3:0] S_NLOAD  = 4'd2;
  localparam logic [3:0] S_NDIST  = 4'd3;
  localparam logic [3:0] S_WCHK   = 4'd4;
  localparam logic [3:0] S_WRDA   = 4'd5;
  localparam logic [3:0] S_WREFA  = 4'd6;
  localparam logic [3:0] S_WRDB   = 4'd7;
  localparam logic [3:0] S_WDIST  = 4'd8;
  localparam logic [3:0] S_WSQRT  = 4'd9;
  localparam logic [3:0] S_TRD    = 4'd10;
  localparam logic [3:0] S_TLOAD  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;
  localparam logic [3:0] S_WAIT   = 4'd13;

  logic [3:0] state, state_next;
  logic [AddrW-1:0] idx, idx_next;
  logic [AddrW-1:0] tgt, tgt_next;
  logic accept;
  logic last_n;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;
  assign last_n = CountW'(idx) + CountW'(1) >= stat.count;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    tgt_next   = tgt;
    ctrl       = '0;
    ctrl.rd_addr = idx;
    ctrl.tgt_idx = tgt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctrl.load_item = 1'b1;
          ctrl.clear_path = action == ACT_CLEAR;
          ctrl.append_point = action == ACT_APPEND;
          if (action == ACT_QUERY) begin
            idx_next = '0;
            state_next = (stat.count == '0) ? S_EMIT : S_NRD;
          end
        end
      end
      S_NRD: begin
        ctrl.rd_issue = 1'b1;
        state_next = S_NLOAD;
      end
      S_NLOAD: begin
        state_next = S_NDIST;
        ctrl.dist_start = 1'b1;
      end
      S_NDIST: begin
        if (stat.dist_done) begin
          if (idx == '0) ctrl.init_best = 1'b1;
          else ctrl.take_best = 1'b1;
          if (last_n) begin
            state_next = S_WAIT;
          end else begin
            idx_next = idx + AddrW'(1);
            state_next = S_NRD;
          end
        end
      end
      S_WAIT: begin
        tgt_next = stat.best_idx;
        ctrl.acc_clear = 1'b1;
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (CountW'(tgt) + CountW'(1) < stat.count && stat.acc_below) begin
          idx_next = tgt;
          state_next = S_WRDA;
        end else begin
          idx_next = tgt;
          state_next = S_TRD;
        end
      end
      S_WRDA: begin
        ctrl.rd_issue = 1'b1;
        idx_next = idx + AddrW'(1);
        state_next = S_WREFA;
      end
      S_WREFA: begin
        ctrl.load_ref = 1'b1;
        state_next = S_WRDB;
      end
      S_WRDB: begin
        // The second read lands before the distance unit takes its first axis.
        ctrl.rd_issue = 1'b1;
        ctrl.dist_start = 1'b1;
        state_next = S_WDIST;
      end
      S_WDIST: begin
        if (stat.dist_done) begin
          ctrl.sqrt_start = 1'b1;
          state_next = S_WSQRT;
        end
      end
      S_WSQRT: begin
        if (stat.sqrt_done) begin
          ctrl.acc_add = 1'b1;
          tgt_next = tgt + AddrW'(1);
          state_next = S_WCHK;
        end
      end
      S_TRD: begin
        ctrl.rd_issue = 1'b1;
        state_next = S_TLOAD;
      end
      S_TLOAD: begin
        ctrl.set_target = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        ctrl.emit = 1'b1;
        ctrl.emit_empty = stat.count == '0;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, scan index and walk target registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      tgt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      tgt   <= tgt_next;
    end
  end

  `PLTS_ASSERT_NEXT(a_emit_idle, clk, rst, ctrl.emit, state == S_IDLE, "emit not followed by idle")
  `PLTS_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !accept, "accept while busy")
  `PLTS_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0({ctrl.clear_path, ctrl.append_point, ctrl.emit}), "conflicting commands")
  `PLTS_ASSERT_IMP(a_walk_bound, clk, rst, state == S_WRDA, CountW'(tgt) + CountW'(1) < stat.count, "walk past end")
endmodule
`default_nettype wire
